FILE: rtl/cta_pkg.sv
// Shared types, constants and helpers for the calendar time adder.
package cta_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  DAY_FIRST = 5'd1;
  localparam logic [4:0]  DAY_LONG  = 5'd31;

  localparam logic [15:0] YEAR_RST   = 16'd2000;
  localparam logic [8:0]  Y400_RST   = 9'd0;     // 2000 mod 400
  localparam logic [15:0] YEAR_MAX   = 16'hFFFF;
  localparam logic [8:0]  Y400_LAST  = 9'd399;
  localparam logic [8:0]  Y400_OFMAX = 9'd335;   // 65535 mod 400

  localparam logic [17:0] SEC_PER_DAY = 18'd86400;
  localparam logic [16:0] SEC_PER_HR  = 17'd3600;
  localparam logic [11:0] SEC_PER_MIN = 12'd60;
  localparam logic [15:0] YEARS_400   = 16'd400;

  // Exact reciprocals: (x >> 4) * R >> S over the full input range.
  localparam logic [13:0] RCP_HR   = 14'd9321;   // 1/225, shift 21
  localparam logic [11:0] RCP_Y400 = 12'd2622;   // 1/25,  shift 16
  localparam logic [10:0] RCP_MIN  = 11'd1093;   // 1/15,  shift 14 (after >> 2)

  // One item as it moves down the decomposition pipeline.
  typedef struct packed {
    logic        op;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [16:0] dpos;   // delta folded into 0..86399
    logic        neg;    // delta was negative: one day owed back
    logic [4:0]  dh;
    logic [7:0]  yq;
    logic [11:0] rem;
    logic [8:0]  y400;
    logic [5:0]  dm;
    logic [5:0]  ds;
  } item_t;

  function automatic logic is_leap(input logic [8:0] y400);
    logic century;
    century = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
    return ((y400[1:0] == 2'b00) && !century) || (y400 == 9'd0);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = DAY_LONG;
    if (month == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage

FILE: rtl/cta_in_if.sv
// Request channel: load or add-seconds request.
interface cta_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic        [15:0] new_year;
  logic        [3:0]  new_month;
  logic        [4:0]  new_day;
  logic        [4:0]  new_hour;
  logic        [5:0]  new_minute;
  logic        [5:0]  new_second;
  logic signed [15:0] delta_seconds;

  modport source (
    output valid, op, new_year, new_month, new_day, new_hour, new_minute,
           new_second, delta_seconds,
    input  ready
  );
  modport sink (
    input  valid, op, new_year, new_month, new_day, new_hour, new_minute,
           new_second, delta_seconds,
    output ready
  );
endinterface

FILE: rtl/cta_out_if.sv
// Result channel: date and time after each request.
interface cta_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic [4:0]  cur_hour;
  logic [5:0]  cur_minute;
  logic [5:0]  cur_second;

  modport source (
    output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
    input  ready
  );
  modport sink (
    input  valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
    output ready
  );
endinterface

FILE: rtl/cta_prep.sv
// Pipeline that splits the delta into h/m/s and reduces the load year mod 400.
module cta_prep (
  input  logic                clk,
  input  logic                rst_n,
  cta_in_if.sink              in_chan,
  output cta_pkg::item_t      item,
  output logic                item_valid,
  input  logic                item_ready
);

  localparam int NST = 5;

  cta_pkg::item_t st_r   [NST];
  cta_pkg::item_t st_nxt [NST];
  logic [NST-1:0] v_r;
  logic [NST-1:0] vin;
  logic [NST:0]   rdy;

  logic signed [17:0] dext;
  logic signed [17:0] dsum;
  logic [26:0]        prod_h;
  logic [23:0]        prod_y;
  logic [16:0]        rem_full;
  logic [15:0]        y400_full;
  logic [20:0]        prod_m;
  logic [11:0]        sec_full;

  assign dext = 18'(in_chan.delta_seconds);
  assign dsum = dext + signed'(cta_pkg::SEC_PER_DAY);

  // stage 0: capture request, fold delta into one day
  always_comb begin
    st_nxt[0]        = '0;
    st_nxt[0].op     = in_chan.op;
    st_nxt[0].year   = in_chan.new_year;
    st_nxt[0].month  = in_chan.new_month;
    st_nxt[0].day    = in_chan.new_day;
    st_nxt[0].hour   = in_chan.new_hour;
    st_nxt[0].minute = in_chan.new_minute;
    st_nxt[0].second = in_chan.new_second;
    st_nxt[0].neg    = in_chan.delta_seconds[15];
    st_nxt[0].dpos   = in_chan.delta_seconds[15] ? dsum[16:0] : dext[16:0];
  end

  // stage 1: hours of delta, year / 400
  assign prod_h = 27'(st_r[0].dpos[16:4]) * 27'(cta_pkg::RCP_HR);
  assign prod_y = 24'(st_r[0].year[15:4]) * 24'(cta_pkg::RCP_Y400);
  always_comb begin
    st_nxt[1]    = st_r[0];
    st_nxt[1].dh = prod_h[25:21];
    st_nxt[1].yq = prod_y[23:16];
  end

  // stage 2: remainders
  assign rem_full  = st_r[1].dpos - 17'(st_r[1].dh) * cta_pkg::SEC_PER_HR;
  assign y400_full = st_r[1].year - 16'(st_r[1].yq) * cta_pkg::YEARS_400;
  always_comb begin
    st_nxt[2]      = st_r[1];
    st_nxt[2].rem  = rem_full[11:0];
    st_nxt[2].y400 = y400_full[8:0];
  end

  // stage 3: minutes of delta
  assign prod_m = 21'(st_r[2].rem[11:2]) * 21'(cta_pkg::RCP_MIN);
  always_comb begin
    st_nxt[3]    = st_r[2];
    st_nxt[3].dm = prod_m[19:14];
  end

  // stage 4: seconds of delta
  assign sec_full = st_r[3].rem - 12'(st_r[3].dm) * cta_pkg::SEC_PER_MIN;
  always_comb begin
    st_nxt[4]    = st_r[3];
    st_nxt[4].ds = sec_full[5:0];
  end

  // a stage loads when empty or when the stage after it moves
  always_comb begin
    rdy[NST] = item_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign vin = {v_r[NST-2:0], in_chan.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k] && vin[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign in_chan.ready = rdy[0];
  assign item          = st_r[NST-1];
  assign item_valid    = v_r[NST-1];

  a_dh_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> st_r[1].dh < 5'd24)
    else $error("delta hours out of range");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> (st_r[2].rem < 12'd3600 && st_r[2].y400 < 9'd400))
    else $error("remainder out of range");

  a_ds_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> (st_r[4].dm < 6'd60 && st_r[4].ds < 6'd60))
    else $error("delta minutes or seconds out of range");

endmodule

FILE: rtl/cta_core.sv
// Date/time state: mixed-radix add with day, month and year carry.
module cta_core (
  input  logic                clk,
  input  logic                rst_n,
  input  cta_pkg::item_t      item,
  input  logic                item_valid,
  output logic                item_ready,
  cta_out_if.source           out_chan
);

  logic [15:0] year_r,   year_nxt;
  logic [3:0]  month_r,  month_nxt;
  logic [4:0]  day_r,    day_nxt;
  logic [4:0]  hour_r,   hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [8:0]  y400_r,   y400_nxt;
  logic        out_valid_r;

  logic        take;
  logic [6:0]  ssum, msum;
  logic [5:0]  hsum;
  logic [1:0]  cs, cm, ch;
  logic [5:0]  sec_add, min_add;
  logic [4:0]  hour_add;
  logic        day_up, day_dn;
  logic        leap;
  logic [4:0]  cur_len, prev_len;
  logic [8:0]  y400_inc, y400_dec;

  assign item_ready = !out_valid_r || out_chan.ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    ssum = 7'(second_r) + 7'(item.ds);
    if (ssum >= 7'd120) begin
      cs = 2'd2; sec_add = 6'(ssum - 7'd120);
    end else if (ssum >= 7'd60) begin
      cs = 2'd1; sec_add = 6'(ssum - 7'd60);
    end else begin
      cs = 2'd0; sec_add = ssum[5:0];
    end

    msum = 7'(minute_r) + 7'(item.dm) + 7'(cs);
    if (msum >= 7'd120) begin
      cm = 2'd2; min_add = 6'(msum - 7'd120);
    end else if (msum >= 7'd60) begin
      cm = 2'd1; min_add = 6'(msum - 7'd60);
    end else begin
      cm = 2'd0; min_add = msum[5:0];
    end

    hsum = 6'(hour_r) + 6'(item.dh) + 6'(cm);
    if (hsum >= 6'd48) begin
      ch = 2'd2; hour_add = 5'(hsum - 6'd48);
    end else if (hsum >= 6'd24) begin
      ch = 2'd1; hour_add = 5'(hsum - 6'd24);
    end else begin
      ch = 2'd0; hour_add = hsum[4:0];
    end
  end

  // net day move is ch minus the day folded into a negative delta
  assign day_up = item.neg ? (ch == 2'd2) : (ch == 2'd1);
  assign day_dn = item.neg && (ch == 2'd0);

  assign leap     = cta_pkg::is_leap(y400_r);
  assign cur_len  = cta_pkg::month_len(month_r, leap);
  assign prev_len = cta_pkg::month_len(4'(month_r - 4'd1), leap);

  // year mod 400 tracks the 16-bit wrap
  assign y400_inc = (year_r == cta_pkg::YEAR_MAX || y400_r == cta_pkg::Y400_LAST) ?
                    9'd0 : 9'(y400_r + 9'd1);
  assign y400_dec = (year_r == 16'd0) ? cta_pkg::Y400_OFMAX :
                    (y400_r == 9'd0) ? cta_pkg::Y400_LAST : 9'(y400_r - 9'd1);

  always_comb begin
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    y400_nxt   = y400_r;
    if (take) begin
      if (item.op == cta_pkg::OP_LOAD) begin
        year_nxt   = item.year;
        month_nxt  = item.month;
        day_nxt    = item.day;
        hour_nxt   = item.hour;
        minute_nxt = item.minute;
        second_nxt = item.second;
        y400_nxt   = item.y400;
      end else begin
        hour_nxt   = hour_add;
        minute_nxt = min_add;
        second_nxt = sec_add;
        if (day_up) begin
          if (day_r >= cur_len) begin
            day_nxt = cta_pkg::DAY_FIRST;
            if (month_r >= cta_pkg::MONTH_DEC) begin
              month_nxt = cta_pkg::MONTH_JAN;
              year_nxt  = 16'(year_r + 16'd1);
              y400_nxt  = y400_inc;
            end else begin
              month_nxt = 4'(month_r + 4'd1);
            end
          end else begin
            day_nxt = 5'(day_r + 5'd1);
          end
        end else if (day_dn) begin
          if (day_r <= cta_pkg::DAY_FIRST) begin
            if (month_r <= cta_pkg::MONTH_JAN) begin
              month_nxt = cta_pkg::MONTH_DEC;
              year_nxt  = 16'(year_r - 16'd1);
              y400_nxt  = y400_dec;
              day_nxt   = cta_pkg::DAY_LONG;
            end else if (month_r > cta_pkg::MONTH_DEC) begin
              month_nxt = cta_pkg::MONTH_DEC;
              day_nxt   = cta_pkg::DAY_LONG;
            end else begin
              month_nxt = 4'(month_r - 4'd1);
              day_nxt   = prev_len;
            end
          end else begin
            day_nxt = 5'(day_r - 5'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r      <= cta_pkg::YEAR_RST;
      month_r     <= cta_pkg::MONTH_JAN;
      day_r       <= cta_pkg::DAY_FIRST;
      hour_r      <= '0;
      minute_r    <= '0;
      second_r    <= '0;
      y400_r      <= cta_pkg::Y400_RST;
      out_valid_r <= 1'b0;
    end else begin
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      y400_r   <= y400_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // state registers double as the result register
  assign out_chan.valid      = out_valid_r;
  assign out_chan.cur_year   = year_r;
  assign out_chan.cur_month  = month_r;
  assign out_chan.cur_day    = day_r;
  assign out_chan.cur_hour   = hour_r;
  assign out_chan.cur_minute = minute_r;
  assign out_chan.cur_second = second_r;

  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.op == cta_pkg::OP_ADD |=>
      (hour_r < 5'd24 && minute_r < 6'd60 && second_r < 6'd60))
    else $error("time of day out of range after add");

  a_y400_range: assert property (@(posedge clk) disable iff (!rst_n)
    y400_r < 9'd400)
    else $error("year mod 400 tracker out of range");

  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("accepted request produced no result");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> (year_r == $past(year_r) && day_r == $past(day_r) &&
               second_r == $past(second_r)))
    else $error("state moved without a request");

  a_same_day: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.op == cta_pkg::OP_ADD && !day_up && !day_dn |=>
      (day_r == $past(day_r) && month_r == $past(month_r)))
    else $error("date changed without a day carry");

endmodule

FILE: rtl/calendar_time_add_seconds.sv
// Path: a request passes the 5-stage delta split pipeline, then the core state register.
// Throughput: one request per cycle unless the result side stalls; the date/time
//   update in the core state register sets it; the delta split pipeline runs ahead.
// Reset (sync, active low): pipeline and result empty, date 2000-01-01 00:00:00.
// Top level of the Gregorian date/time register with signed seconds adder.
module calendar_time_add_seconds (
  input  logic        clk,
  input  logic        rst_n,
  cta_in_if.sink      in_chan,
  cta_out_if.source   out_chan
);

  cta_pkg::item_t item;
  logic           item_valid;
  logic           item_ready;

  cta_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  cta_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .out_chan   (out_chan)
  );

endmodule

FILE: tb/sv/calendar_time_add_seconds_test.sv
// Self-checking testbench for calendar_time_add_seconds: load and add-seconds requests.
`timescale 1ns / 1ps

module calendar_time_add_seconds_test;

  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic               op;
    logic        [15:0] year;
    logic        [3:0]  month;
    logic        [4:0]  day;
    logic        [4:0]  hour;
    logic        [5:0]  minute;
    logic        [5:0]  second;
    logic signed [15:0] delta;
  } req_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_t;

  logic clk = 1'b0;
  logic rst_n;

  cta_in_if  in_chan ();
  cta_out_if out_chan ();

  calendar_time_add_seconds dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #2 clk = ~clk;

  date_t tracked;
  date_t pending_dates[$];
  bit    no_gaps;
  int    hold_cycles;
  int    cycle_count;
  int    n_loads;
  int    n_adds;
  int    n_rollovers;
  int    n_checked;
  int    n_mismatch;

  function automatic bit year_is_leap(input logic [15:0] year);
    return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
  endfunction

  // invalid months (0, 13..15) count as 31 days
  function automatic logic [4:0] month_days(input logic [15:0] year,
                                            input logic [3:0] month);
    logic [4:0] len;
    case (month)
      cta_pkg::MONTH_FEB:        len = year_is_leap(year) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic date_t next_date(input date_t cur, input req_t r);
    date_t nd;
    int    tod;
    int    carry;
    nd = cur;
    if (r.op == cta_pkg::OP_LOAD) begin
      nd = '{r.year, r.month, r.day, r.hour, r.minute, r.second};
    end else begin
      tod = int'(cur.hour) * 3600 + int'(cur.minute) * 60 + int'(cur.second)
            + int'($signed(r.delta));
      carry = 0;
      if (tod >= 86400) begin
        tod -= 86400;
        carry = 1;
      end else if (tod < 0) begin
        tod += 86400;
        carry = -1;
      end
      nd.hour   = 5'(tod / 3600);
      nd.minute = 6'((tod % 3600) / 60);
      nd.second = 6'(tod % 60);
      if (carry > 0) begin
        if (cur.day >= month_days(cur.year, cur.month)) begin
          nd.day = cta_pkg::DAY_FIRST;
          if (cur.month >= cta_pkg::MONTH_DEC) begin
            nd.month = cta_pkg::MONTH_JAN;
            nd.year  = cur.year + 16'd1;
          end else begin
            nd.month = cur.month + 4'd1;
          end
        end else begin
          nd.day = cur.day + 5'd1;
        end
      end else if (carry < 0) begin
        if (cur.day <= cta_pkg::DAY_FIRST) begin
          if (cur.month <= cta_pkg::MONTH_JAN) begin
            nd.month = cta_pkg::MONTH_DEC;
            nd.year  = cur.year - 16'd1;
          end else if (cur.month > cta_pkg::MONTH_DEC) begin
            nd.month = cta_pkg::MONTH_DEC;
          end else begin
            nd.month = cur.month - 4'd1;
          end
          nd.day = month_days(nd.year, nd.month);
        end else begin
          nd.day = cur.day - 5'd1;
        end
      end
    end
    return nd;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a back-to-back request keeps it up.
  task automatic send_request(input req_t r);
    int    gap;
    date_t prev;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.op            = r.op;
    in_chan.new_year      = r.year;
    in_chan.new_month     = r.month;
    in_chan.new_day       = r.day;
    in_chan.new_hour      = r.hour;
    in_chan.new_minute    = r.minute;
    in_chan.new_second    = r.second;
    in_chan.delta_seconds = r.delta;
    in_chan.valid         = 1'b1;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    prev    = tracked;
    tracked = next_date(tracked, r);
    pending_dates.push_back(tracked);
    if (r.op == cta_pkg::OP_LOAD) begin
      n_loads++;
    end else begin
      n_adds++;
      if (tracked.day != prev.day || tracked.month != prev.month) n_rollovers++;
    end
    @(negedge clk);
  endtask

  function automatic req_t noise_request();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(req_t)-1:0];
  endfunction

  task automatic send_load(input logic [15:0] year, input logic [3:0] month,
                           input logic [4:0] day, input logic [4:0] hour,
                           input logic [5:0] minute, input logic [5:0] second);
    req_t r;
    r        = noise_request();
    r.op     = cta_pkg::OP_LOAD;
    r.year   = year;
    r.month  = month;
    r.day    = day;
    r.hour   = hour;
    r.minute = minute;
    r.second = second;
    send_request(r);
  endtask

  task automatic send_add(input int delta);
    req_t r;
    r       = noise_request();
    r.op    = cta_pkg::OP_ADD;
    r.delta = 16'(delta);
    send_request(r);
  endtask

  task automatic wait_drain();
    in_chan.valid = 1'b0;
    while (pending_dates.size() != 0) @(negedge clk);
  endtask

  task automatic test_reset_state();
    send_add(0);
    send_add(-1);
  endtask

  task automatic test_field_extremes();
    send_load(16'hFFFF, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_load(16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_add(32767);
    send_add(-32768);
  endtask

  task automatic test_year_wrap();
    send_load(16'hFFFF, cta_pkg::MONTH_DEC, 5'd31, 5'd23, 6'd59, 6'd59);
    send_add(1);
    send_add(-1);
  endtask

  task automatic test_leap_years();
    logic [15:0] fwd_years[3];
    logic [15:0] back_years[2];
    fwd_years  = '{16'd2024, 16'd1900, 16'd2000};
    back_years = '{16'd2100, 16'd2400};
    foreach (fwd_years[i]) begin
      send_load(fwd_years[i], cta_pkg::MONTH_FEB, 5'd28, 5'd23, 6'd59, 6'd50);
      send_add(10);
    end
    foreach (back_years[i]) begin
      send_load(back_years[i], 4'd3, cta_pkg::DAY_FIRST, 5'd0, 6'd0, 6'd5);
      send_add(-6);
    end
  endtask

  task automatic test_invalid_months();
    send_load(16'd2023, 4'd13, 5'd31, 5'd23, 6'd0, 6'd0);
    send_add(3600);
    send_load(16'd2023, 4'd14, cta_pkg::DAY_FIRST, 5'd0, 6'd0, 6'd0);
    send_add(-1);
    send_load(16'd5, 4'd0, 5'd31, 5'd23, 6'd59, 6'd59);
    send_add(1);
  endtask

  // Mostly valid dates parked near month, year and century edges, then
  // walked with adds; a few raw loads throw the state out of range.
  task automatic test_random_walk(input int count);
    logic [15:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [4:0]  len;
    logic [4:0]  h;
    logic [5:0]  mi;
    int          dv;
    req_t        r;
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= count / 2) && (i < count / 2 + 200);
      if ($urandom_range(0, 9) < 2) begin
        if ($urandom_range(0, 3) == 0) begin
          r    = noise_request();
          r.op = cta_pkg::OP_LOAD;
          send_request(r);
        end else begin
          case ($urandom_range(0, 3))
            0:       y = 16'($urandom);
            1:       y = 16'($urandom_range(0, 163) * 100 + $urandom_range(0, 2) - 1);
            2:       y = 16'(1990 + $urandom_range(0, 40));
            default: y = 16'($urandom_range(65533, 65538));
          endcase
          m   = 4'($urandom_range(1, 12));
          len = month_days(y, m);
          case ($urandom_range(0, 2))
            0:       d = len;
            1:       d = cta_pkg::DAY_FIRST;
            default: d = 5'($urandom_range(1, len));
          endcase
          case ($urandom_range(0, 2))
            0:       begin h = 5'd23; mi = 6'd59; end
            1:       begin h = 5'd0;  mi = 6'd0;  end
            default: begin h = 5'($urandom_range(0, 23)); mi = 6'($urandom_range(0, 59)); end
          endcase
          send_load(y, m, d, h, mi, 6'($urandom_range(0, 59)));
        end
      end else begin
        case ($urandom_range(0, 3))
          0:       dv = int'($signed(16'($urandom)));
          1:       dv = int'($urandom_range(0, 200)) - 100;
          2:       dv = 32767 - int'($urandom_range(0, 100));
          default: dv = -32768 + int'($urandom_range(0, 100));
        endcase
        send_add(dv);
      end
    end
    no_gaps = 1'b0;
  endtask

  // Result side holds off while requests keep coming back to back.
  task automatic test_backpressure();
    hold_cycles = 80;
    no_gaps     = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_add(int'($signed(16'($urandom))));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_drain_restart();
    wait_drain();
    send_load(16'd1999, cta_pkg::MONTH_DEC, 5'd31, 5'd23, 6'd59, 6'd59);
    for (int i = 0; i < 60; i++) begin
      send_add(int'($urandom_range(0, 4000)) - 2000);
    end
  endtask

  // result side: random stall per result, long hold-off on request
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 16);
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall != 0) begin
        out_chan.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    date_t got;
    date_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got = '{out_chan.cur_year, out_chan.cur_month, out_chan.cur_day,
              out_chan.cur_hour, out_chan.cur_minute, out_chan.cur_second};
      if (pending_dates.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("%0t: result with no request pending: %0d-%0d-%0d %0d:%0d:%0d",
                   $realtime, got.year, got.month, got.day, got.hour, got.minute,
                   got.second);
      end else begin
        want = pending_dates.pop_front();
        n_checked++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display({"%0t: date mismatch: expected %0d-%0d-%0d %0d:%0d:%0d,",
                      " got %0d-%0d-%0d %0d:%0d:%0d"},
                     $realtime, want.year, want.month, want.day, want.hour, want.minute,
                     want.second, got.year, got.month, got.day, got.hour, got.minute,
                     got.second);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.op            = cta_pkg::OP_LOAD;
    in_chan.new_year      = '0;
    in_chan.new_month     = '0;
    in_chan.new_day       = '0;
    in_chan.new_hour      = '0;
    in_chan.new_minute    = '0;
    in_chan.new_second    = '0;
    in_chan.delta_seconds = '0;
    tracked               = '{cta_pkg::YEAR_RST, cta_pkg::MONTH_JAN, cta_pkg::DAY_FIRST,
                              5'd0, 6'd0, 6'd0};
    no_gaps               = 1'b0;
    hold_cycles           = 0;
    cycle_count           = 0;
    n_loads               = 0;
    n_adds                = 0;
    n_rollovers           = 0;
    n_checked             = 0;
    n_mismatch            = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_field_extremes();
    test_year_wrap();
    test_leap_years();
    test_invalid_months();
    test_random_walk(RANDOM_ITEMS);
    test_backpressure();
    test_drain_restart();

    wait_drain();
    repeat (20) @(posedge clk);
    n_mismatch += pending_dates.size();

    $display("Sent %0d loads and %0d second adds, %0d of which moved the date.",
             n_loads, n_adds, n_rollovers);
    $display("Compared %0d results: %0d mismatches.", n_checked, n_mismatch);
    if (n_mismatch == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
